/* sv/weighted_word_list_match_unit_defines.svh */
// Assertion macros shared by the weighted word list match unit.
`ifndef WEIGHTED_WORD_LIST_MATCH_UNIT_DEFINES_SVH
`define WEIGHTED_WORD_LIST_MATCH_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WWLM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define WWLM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/wwlm_pkg.sv */
// Shared constants, codes and types of the weighted word list match unit.
package wwlm_pkg;

	// Table geometry.
	localparam int NUM_WORDS    = 16;
	localparam int MAX_WORD_LEN = 16;

	// Field widths.
	localparam int ENTRY_W    = 4;
	localparam int POS_W      = 4;
	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 5;
	localparam int WEIGHT_W   = 8;
	localparam int SEEN_W     = $clog2(MAX_WORD_LEN + 1);
	localparam int HIST_IDX_W = $clog2(MAX_WORD_LEN);
	localparam int SUM_W      = 12;
	localparam int SCORE_W    = 13;
	localparam int THR_W      = 12;

	// Configuration port.
	localparam int APB_ADDR_W   = 3;
	localparam int APB_DATA_W   = 32;
	localparam int REG_ADDR_LSB = 2;

	localparam logic [SUM_W-1:0]          SUM_MAX       = {SUM_W{1'b1}};
	localparam logic [THR_W-1:0]          THR_RESET     = THR_W'(1);
	localparam logic signed [SCORE_W-1:0] SCORE_NONE    = {SCORE_W{1'b1}};

	// Item actions.
	typedef enum logic [1:0] {
		ACT_LOAD_BYTE = 2'd0,
		ACT_LOAD_LEN  = 2'd1,
		ACT_MSG_BYTE  = 2'd2,
		ACT_END_MSG   = 2'd3
	} act_t;

	// Register indexes.
	typedef enum logic {
		REG_ENABLED   = 1'b0,
		REG_THRESHOLD = 1'b1
	} reg_idx_t;

	// Message bytes as seen by the cells; entry 0 is the byte now arriving.
	typedef logic [MAX_WORD_LEN-1:0][BYTE_W-1:0] hist_t;

	// Token handed from cell to cell.
	typedef struct packed {
		act_t                act;
		logic [ENTRY_W-1:0]  entry;
		logic [POS_W-1:0]    position;
		logic [BYTE_W-1:0]   byte_value;
		logic [LEN_W-1:0]    word_length;
		logic [WEIGHT_W-1:0] word_weight;
		hist_t               hist;
		logic [SEEN_W-1:0]   seen;
		logic                any;
		logic [SUM_W-1:0]    sum;
	} tok_t;

	// Configuration as used by the result stage.
	typedef struct packed {
		logic             enabled;
		logic [THR_W-1:0] threshold;
	} cfg_t;

endpackage

/* sv/wwlm_item_if.sv */
// Input item channel of the weighted word list match unit.
interface wwlm_item_if;
	import wwlm_pkg::*;

	logic                valid;
	logic                ready;
	act_t                action;
	logic [ENTRY_W-1:0]  entry;
	logic [POS_W-1:0]    position;
	logic [BYTE_W-1:0]   byte_value;
	logic [LEN_W-1:0]    word_length;
	logic [WEIGHT_W-1:0] word_weight;

	modport source (
		output valid, action, entry, position, byte_value, word_length, word_weight,
		input  ready
	);

	modport sink (
		input  valid, action, entry, position, byte_value, word_length, word_weight,
		output ready
	);

endinterface

/* sv/wwlm_result_if.sv */
// Result channel of the weighted word list match unit.
interface wwlm_result_if;
	import wwlm_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [SCORE_W-1:0] score;
	logic                      blocked;

	modport source (
		output valid, score, blocked,
		input  ready
	);

	modport sink (
		input  valid, score, blocked,
		output ready
	);

endinterface

/* sv/wwlm_cfg.sv */
// APB-style configuration registers: enable and block threshold.
module wwlm_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [wwlm_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [wwlm_pkg::APB_DATA_W-1:0] pwdata,
	output logic [wwlm_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	output wwlm_pkg::cfg_t                  cfg
);
	import wwlm_pkg::*;

	logic             enabled_q;
	logic [THR_W-1:0] threshold_q;
	reg_idx_t         reg_idx;
	logic             wr_en;

	// Register decode; pready is always high, so the access phase never waits.
	assign reg_idx = reg_idx_t'(paddr[REG_ADDR_LSB]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q   <= 1'b0;
			threshold_q <= THR_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ENABLED:   enabled_q   <= pwdata[0];
				REG_THRESHOLD: threshold_q <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back.
	always_comb begin
		case (reg_idx)
			REG_ENABLED:   prdata = APB_DATA_W'(enabled_q);
			REG_THRESHOLD: prdata = APB_DATA_W'(threshold_q);
			default:       prdata = '0;
		endcase
	end

	assign cfg.enabled   = enabled_q;
	assign cfg.threshold = threshold_q;

endmodule

/* sv/wwlm_window.sv */
// Head of the row: keeps the recent message bytes and builds the token for the first cell.
module wwlm_window (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  wwlm_pkg::act_t                action,
	input  logic [wwlm_pkg::ENTRY_W-1:0]  entry,
	input  logic [wwlm_pkg::POS_W-1:0]    position,
	input  logic [wwlm_pkg::BYTE_W-1:0]   byte_value,
	input  logic [wwlm_pkg::LEN_W-1:0]    word_length,
	input  logic [wwlm_pkg::WEIGHT_W-1:0] word_weight,
	output wwlm_pkg::tok_t                tok
);
	import wwlm_pkg::*;

	logic [BYTE_W-1:0] recent_q [MAX_WORD_LEN-1];
	logic [SEEN_W-1:0] seen_q;
	logic [SEEN_W-1:0] seen_next;

	// Count of message bytes, saturating at the longest word.
	assign seen_next = (seen_q < SEEN_W'(MAX_WORD_LEN)) ? seen_q + SEEN_W'(1) : seen_q;

	// Shift line of recent bytes; an end of message clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_WORD_LEN - 1; k++) begin
				recent_q[k] <= '0;
			end
			seen_q <= '0;
		end else if (take) begin
			if (action == ACT_MSG_BYTE) begin
				recent_q[0] <= byte_value;
				for (int k = 1; k < MAX_WORD_LEN - 1; k++) begin
					recent_q[k] <= recent_q[k-1];
				end
				seen_q <= seen_next;
			end else if (action == ACT_END_MSG) begin
				for (int k = 0; k < MAX_WORD_LEN - 1; k++) begin
					recent_q[k] <= '0;
				end
				seen_q <= '0;
			end
		end
	end

	// Token: the item itself, the byte window and an empty running sum.
	always_comb begin
		tok.act         = action;
		tok.entry       = entry;
		tok.position    = position;
		tok.byte_value  = byte_value;
		tok.word_length = word_length;
		tok.word_weight = word_weight;
		tok.hist[0]     = byte_value;
		for (int k = 1; k < MAX_WORD_LEN; k++) begin
			tok.hist[k] = recent_q[k-1];
		end
		tok.seen = seen_next;
		tok.any  = 1'b0;
		tok.sum  = '0;
	end

endmodule

/* sv/wwlm_cell.sv */
// One word slot of the row: holds a word, matches it and adds its weight at message end.
`include "weighted_word_list_match_unit_defines.svh"

module wwlm_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [wwlm_pkg::ENTRY_W-1:0] slot,
	input  logic                         advance,
	input  logic                         vld_in,
	input  wwlm_pkg::tok_t               tok_in,
	output logic                         vld_out,
	output wwlm_pkg::tok_t               tok_out
);
	import wwlm_pkg::*;

	logic [BYTE_W-1:0]   word_q [MAX_WORD_LEN];
	logic [LEN_W-1:0]    len_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic                found_q;
	logic                vld_q;
	tok_t                tok_q;

	logic [LEN_W-1:0]        tap_idx [MAX_WORD_LEN];
	logic [MAX_WORD_LEN-1:0] byte_ok;
	logic                    hit;
	logic                    take;
	logic                    own;
	logic                    counts;
	logic [LEN_W-1:0]        len_sat;
	logic [SUM_W:0]          sum_ext;
	logic [SUM_W-1:0]        sum_new;
	tok_t                    tok_next;

	// Word byte i lines up with the message byte len-1-i places back.
	always_comb begin
		for (int i = 0; i < MAX_WORD_LEN; i++) begin
			tap_idx[i] = len_q - LEN_W'(1) - LEN_W'(i);
			byte_ok[i] = (LEN_W'(i) >= len_q) ||
				(word_q[i] == tok_in.hist[tap_idx[i][HIST_IDX_W-1:0]]);
		end
	end

	assign hit     = (len_q != '0) && (len_q <= tok_in.seen) && (&byte_ok);
	assign take    = advance && vld_in;
	assign own     = (tok_in.entry == slot);
	assign counts  = found_q && (len_q != '0);
	assign len_sat = (tok_in.word_length > LEN_W'(MAX_WORD_LEN)) ?
		LEN_W'(MAX_WORD_LEN) : tok_in.word_length;

	// Saturating running sum.
	assign sum_ext = {1'b0, tok_in.sum} + (SUM_W+1)'(weight_q);
	assign sum_new = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];

	// Word bytes and weight; no reset, written by load items only.
	always_ff @(posedge clk) begin
		if (take && own) begin
			if (tok_in.act == ACT_LOAD_BYTE) begin
				word_q[tok_in.position] <= tok_in.byte_value;
			end
			if (tok_in.act == ACT_LOAD_LEN) begin
				weight_q <= tok_in.word_weight;
			end
		end
	end

	// Length and found mark.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			found_q <= 1'b0;
		end else if (take) begin
			case (tok_in.act)
				ACT_LOAD_LEN: begin
					if (own) begin
						len_q   <= len_sat;
						found_q <= 1'b0;
					end
				end
				ACT_MSG_BYTE: begin
					if (hit) begin
						found_q <= 1'b1;
					end
				end
				ACT_END_MSG:  found_q <= 1'b0;
				default: ;
			endcase
		end
	end

	// Token to the next cell; an end of message picks up this slot's weight when found.
	always_comb begin
		tok_next = tok_in;
		if (vld_in && (tok_in.act == ACT_END_MSG) && counts) begin
			tok_next.sum = sum_new;
			tok_next.any = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (advance) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tok_q <= tok_next;
		end
	end

	assign vld_out = vld_q;
	assign tok_out = tok_q;

	`WWLM_ASSERT_IMP(a_found_needs_len, clk, arst_n, found_q, len_q != '0, "found mark on empty slot")
	`WWLM_ASSERT_NXT(a_end_clears_found, clk, arst_n, take && (tok_in.act == ACT_END_MSG), !found_q, "found mark survived message end")
	`WWLM_ASSERT_IMP(a_len_in_range, clk, arst_n, 1'b1, len_q <= LEN_W'(MAX_WORD_LEN), "word length above maximum")

endmodule

/* sv/wwlm_result.sv */
// Tail of the row: turns the final sum into score and block flag and holds the result.
`include "weighted_word_list_match_unit_defines.svh"

module wwlm_result (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  advance,
	input  logic                                  vld_in,
	input  wwlm_pkg::tok_t                        tok_in,
	input  wwlm_pkg::cfg_t                        cfg,
	output logic                                  valid,
	output logic signed [wwlm_pkg::SCORE_W-1:0]   score,
	output logic                                  blocked
);
	import wwlm_pkg::*;

	logic                      valid_q;
	logic signed [SCORE_W-1:0] score_q;
	logic                      blocked_q;
	logic                      live;
	logic                      is_end;

	// Scoring is live only when enabled, with a threshold and at least one word found.
	assign live   = cfg.enabled && (cfg.threshold != '0) && tok_in.any;
	assign is_end = vld_in && (tok_in.act == ACT_END_MSG);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= is_end;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (live) begin
				score_q   <= $signed({1'b0, tok_in.sum});
				blocked_q <= (tok_in.sum >= cfg.threshold);
			end else begin
				score_q   <= SCORE_NONE;
				blocked_q <= 1'b0;
			end
		end
	end

	assign valid   = valid_q;
	assign score   = score_q;
	assign blocked = blocked_q;

	`WWLM_ASSERT_IMP(a_none_not_blocked, clk, arst_n, valid_q && (score_q == SCORE_NONE), !blocked_q, "blocked without a score")
	`WWLM_ASSERT_IMP(a_blocked_at_thr, clk, arst_n, valid_q && blocked_q, (score_q[SCORE_W-1] == 1'b0) && (score_q[SUM_W-1:0] >= cfg.threshold), "blocked below threshold")

endmodule

/* sv/weighted_word_list_match_unit.sv */
// Top level of the weighted word list match unit: window, row of word cells, result stage.
//
// Channel  Dir  Handshake       Carries
// item     in   valid / ready   action, entry, position, byte_value, word_length, word_weight
// result   out  valid / ready   score, blocked (one per end-of-message item)
// apb      in   psel / penable  enable and block threshold registers
//
// While the row moves, one item is taken per cycle and every item walks the row, one cell a cycle.
// The first cell takes an item at its transfer edge; its token then passes each cell's register in turn
// and, after the last cell, is loaded into the output register, from which the result transfer follows.
// The whole row holds while the output register is full and not taken; ready follows that.
// Reset empties every word slot and the message window; no clearing pass is needed.
module weighted_word_list_match_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	wwlm_item_if.sink                       item,
	wwlm_result_if.source                   result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [wwlm_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [wwlm_pkg::APB_DATA_W-1:0] pwdata,
	output logic [wwlm_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);
	import wwlm_pkg::*;

	cfg_t cfg;
	logic advance;
	logic take;
	logic vld_c [NUM_WORDS+1];
	tok_t tok_c [NUM_WORDS+1];
	logic res_valid;

	// The row moves whenever the output register can take what arrives.
	assign advance     = !res_valid || result.ready;
	assign take        = item.valid && advance;
	assign item.ready  = advance;
	assign vld_c[0]    = item.valid;
	assign result.valid = res_valid;

	// Configuration registers.
	wwlm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Message window at the head of the row.
	wwlm_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.action      (item.action),
		.entry       (item.entry),
		.position    (item.position),
		.byte_value  (item.byte_value),
		.word_length (item.word_length),
		.word_weight (item.word_weight),
		.tok         (tok_c[0])
	);

	// Row of word cells, one per slot.
	for (genvar g = 0; g < NUM_WORDS; g++) begin : g_cell
		wwlm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.slot    (ENTRY_W'(g)),
			.advance (advance),
			.vld_in  (vld_c[g]),
			.tok_in  (tok_c[g]),
			.vld_out (vld_c[g+1]),
			.tok_out (tok_c[g+1])
		);
	end

	// Result stage and output register.
	wwlm_result u_result (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.vld_in  (vld_c[NUM_WORDS]),
		.tok_in  (tok_c[NUM_WORDS]),
		.cfg     (cfg),
		.valid   (res_valid),
		.score   (result.score),
		.blocked (result.blocked)
	);

endmodule
